// ===== rtl/bfa_pkg.sv =====
// ============================================================================
// Bitmap frame allocator package
// Shared constants, codes, types and helper functions of the allocator.
// ============================================================================
`default_nettype none

package bfa_pkg;

    localparam int MAX_FRAMES = 32768;
    localparam int MAP_BYTES  = MAX_FRAMES / 8;
    localparam int MAP_AW     = $clog2(MAP_BYTES);
    localparam int BYTE_CW    = MAP_AW + 1;

    localparam int FRAME_W    = 20;
    localparam int COUNT_W    = 16;
    localparam int SIZE_W     = 16;
    localparam int CUR_W      = FRAME_W + 1;
    localparam int FUNC_W     = 2;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [FUNC_W-1:0] FN_INIT    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_GET     = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_MARK    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_USED     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_USED = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_IN_POOL = 2'd2;

    localparam logic [7:0] BYTE_ALL_FREE = 8'hFF;
    localparam logic [7:0] BYTE_INFO     = 8'h7F;
    localparam logic [7:0] BYTE_TOP_BIT  = 8'h80;

    typedef struct packed {
        logic [FRAME_W-1:0] pool_base;
        logic [SIZE_W-1:0]  pool_size;
        logic               info_in_pool;
    } t_cfg;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
    } t_op;

    typedef struct packed {
        logic [FRAME_W-1:0] alloc_frame;
        logic [STAT_W-1:0]  status;
        logic [SIZE_W-1:0]  free_left;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    function automatic logic [SIZE_W-1:0] work_size(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] s;
        s = (32'(size) > MAX_FRAMES) ? SIZE_W'(MAX_FRAMES) : size;
        return {s[SIZE_W-1:3], 3'b000};
    endfunction

    // Position of the first free frame in a byte, counted from the top bit.
    function automatic logic [2:0] first_set(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                pos = 3'(7 - i);
            end
        end
        return pos;
    endfunction

    function automatic logic [7:0] bit_mask(input logic [2:0] pos);
        return BYTE_TOP_BIT >> pos;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bfa_ram.sv =====
// ============================================================================
// Generic single-port RAM
// One read or write port; the read data is registered.
// ============================================================================
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/bfa_seq.sv =====
// ============================================================================
// Bitmap frame allocator sequencer
// Runs init, get, release and mark against the bitmap memory and free count.
// ============================================================================
`default_nettype none

module bfa_seq
    import bfa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_valid,
    input  wire t_op      i_op,
    output logic          o_ready,
    input  wire logic     i_out_free,
    output logic          o_done,
    output t_result       o_res,
    output t_mem_req      o_mem,
    input  wire logic [7:0] i_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [CUR_W-1:0]    r_cur, n_cur;
    logic [COUNT_W-1:0]  r_left, n_left;
    logic [BYTE_CW-1:0]  r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [MAP_AW-1:0]   r_pidx, n_pidx;
    logic [SIZE_W-1:0]   r_free_total, n_free_total;
    logic [FRAME_W-1:0]  r_res_frame, n_res_frame;
    logic [STAT_W-1:0]   r_res_status, n_res_status;

    logic [SIZE_W-1:0]   ws;
    logic [BYTE_CW-1:0]  work_bytes;
    logic [BYTE_CW-1:0]  size_bytes;
    logic                size_ok;
    logic [CUR_W-1:0]    cur_off;
    logic                cur_ok;
    logic [7:0]          cur_mask;
    logic [2:0]          fs;
    logic                dec_ok;
    logic                inc_ok;
    t_mem_req            mem;

    assign ws         = work_size(i_cfg.pool_size);
    assign work_bytes = ws[SIZE_W-1:3];
    assign size_bytes = i_cfg.pool_size[SIZE_W-1:3];
    assign size_ok    = (i_cfg.pool_size >= SIZE_W'(8))
                     && (32'(i_cfg.pool_size) <= MAX_FRAMES)
                     && (i_cfg.pool_size[2:0] == 3'b000);
    assign cur_off    = r_cur - {1'b0, i_cfg.pool_base};
    assign cur_ok     = (r_cur >= {1'b0, i_cfg.pool_base})
                     && (cur_off < CUR_W'(ws));
    assign cur_mask   = bit_mask(cur_off[2:0]);
    assign fs         = first_set(i_rdata);
    assign dec_ok     = (r_free_total != '0);
    assign inc_ok     = (r_free_total != '1);

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_cur        = r_cur;
        n_left       = r_left;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_free_total = r_free_total;
        n_res_frame  = r_res_frame;
        n_res_status = r_res_status;
        mem          = '0;
        o_done       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func       = i_op.func;
                    n_cur        = {1'b0, i_op.frame};
                    n_left       = i_op.count;
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    n_res_frame  = '0;
                    n_res_status = ST_OK;
                    unique case (i_op.func)
                        FN_INIT: begin
                            if (!size_ok) begin
                                n_res_status = ST_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_INIT;
                            end
                        end
                        FN_GET: begin
                            if (!dec_ok || work_bytes == '0) begin
                                n_res_status = ST_NO_FREE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        FN_RELEASE: begin
                            n_state = S_CHK;
                        end
                        FN_MARK: begin
                            n_state = (i_op.count == '0) ? S_DONE : S_CHK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INIT: begin
                mem.we    = 1'b1;
                mem.addr  = r_idx[MAP_AW-1:0];
                mem.wdata = (r_idx == '0 && i_cfg.info_in_pool) ? BYTE_INFO : BYTE_ALL_FREE;
                n_idx     = r_idx + BYTE_CW'(1);
                if (r_idx == size_bytes - BYTE_CW'(1)) begin
                    n_free_total = i_cfg.pool_size - SIZE_W'(i_cfg.info_in_pool);
                    n_state      = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_pend && i_rdata != '0) begin
                    mem.we       = 1'b1;
                    mem.addr     = r_pidx;
                    mem.wdata    = i_rdata & ~bit_mask(fs);
                    n_free_total = r_free_total - SIZE_W'(dec_ok);
                    n_res_frame  = i_cfg.pool_base + FRAME_W'({r_pidx, fs});
                    n_res_status = ST_OK;
                    n_pend       = 1'b0;
                    n_state      = S_DONE;
                end else if (r_pend && {1'b0, r_pidx} == work_bytes - BYTE_CW'(1)) begin
                    n_res_status = ST_NO_FREE;
                    n_pend       = 1'b0;
                    n_state      = S_DONE;
                end else if (r_idx < work_bytes) begin
                    mem.addr = r_idx[MAP_AW-1:0];
                    n_idx    = r_idx + BYTE_CW'(1);
                    n_pend   = 1'b1;
                    n_pidx   = r_idx[MAP_AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_CHK: begin
                if (!cur_ok) begin
                    n_res_status = ST_RANGE;
                    n_state      = S_DONE;
                end else begin
                    mem.addr = cur_off[MAP_AW+2:3];
                    n_state  = S_MOD;
                end
            end
            S_MOD: begin
                mem.addr = cur_off[MAP_AW+2:3];
                if (r_func == FN_RELEASE) begin
                    if ((i_rdata & cur_mask) != '0) begin
                        n_res_status = ST_NOT_USED;
                    end else begin
                        mem.we       = 1'b1;
                        mem.wdata    = i_rdata | cur_mask;
                        n_free_total = r_free_total + SIZE_W'(inc_ok);
                    end
                    n_state = S_DONE;
                end else begin
                    if ((i_rdata & cur_mask) == '0) begin
                        n_res_status = ST_USED;
                        n_state      = S_DONE;
                    end else begin
                        mem.we       = 1'b1;
                        mem.wdata    = i_rdata & ~cur_mask;
                        n_free_total = r_free_total - SIZE_W'(dec_ok);
                        if (r_left == COUNT_W'(1)) begin
                            n_state = S_DONE;
                        end else begin
                            n_left  = r_left - COUNT_W'(1);
                            n_cur   = r_cur + CUR_W'(1);
                            n_state = S_CHK;
                        end
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend       <= 1'b0;
            r_free_total <= '0;
        end else begin
            r_state      <= n_state;
            r_pend       <= n_pend;
            r_free_total <= n_free_total;
        end
        r_func       <= n_func;
        r_cur        <= n_cur;
        r_left       <= n_left;
        r_idx        <= n_idx;
        r_pidx       <= n_pidx;
        r_res_frame  <= n_res_frame;
        r_res_status <= n_res_status;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_mem   = mem;
    assign o_res   = '{alloc_frame: r_res_frame, status: r_res_status, free_left: r_free_total};

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem.we |-> (r_state == S_INIT || r_state == S_SCAN || r_state == S_MOD))
        else $error("bitmap write outside a modifying state");

    a_total_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_free_total)) |->
        ($past(r_state) == S_INIT || $past(r_state) == S_SCAN || $past(r_state) == S_MOD))
        else $error("free count changed outside a modifying state");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_free_total != '0))
        else $error("scan running with an empty pool");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pend) |-> ({1'b0, r_pidx} < work_bytes))
        else $error("scan read beyond the working pool");

endmodule

`default_nettype wire

// ===== rtl/bitmap_frame_allocator.sv =====
// ============================================================================
// Bitmap frame allocator
// Page frame pool with a free bitmap in memory, a free count and a status
// for every operation.
// ============================================================================
// Each input word carries one operation and yields exactly one output word.
// The bitmap sits in a single-port RAM of one byte per eight frames, and all
// timing follows from that port. Init writes one byte per cycle. Get reads
// one byte per cycle from the low end and stops at the first byte with a
// free frame, or after the whole working pool when none is free; a get on
// an empty free count ends with no free status and scans nothing. One
// output word waiting to be taken does not stop the block from accepting the
// next operation; the result of that operation then waits in the sequencer,
// which holds off input until the word is taken. The user must write the
// configuration only while idle; the block itself does not enforce it.
`default_nettype none

module bitmap_frame_allocator
    import bfa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [39:0]           i_s_axis_tdata,  // frame[19:0], count[35:20]
    input  wire logic [1:0]            i_s_axis_tuser,  // func[1:0]
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [39:0]           o_m_axis_tdata   // alloc_frame[19:0],
                                                        // status[22:20],
                                                        // free_left[38:23]
);

    logic [FRAME_W-1:0] r_pool_base;
    logic [SIZE_W-1:0]  r_pool_size;
    logic               r_info_in_pool;
    logic               r_out_valid;
    logic [39:0]        r_out_data;

    t_cfg       cfg;
    t_op        op;
    t_result    res;
    t_mem_req   mem;
    logic [7:0] rdata;
    logic       seq_ready;
    logic       seq_done;
    logic       out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base    <= '0;
            r_pool_size    <= SIZE_W'(8);
            r_info_in_pool <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POOL_BASE:    r_pool_base    <= i_cfg_data[FRAME_W-1:0];
                CFG_POOL_SIZE:    r_pool_size    <= i_cfg_data[SIZE_W-1:0];
                CFG_INFO_IN_POOL: r_info_in_pool <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = '{pool_base: r_pool_base, pool_size: r_pool_size,
                   info_in_pool: r_info_in_pool};
    assign op  = '{func: i_s_axis_tuser, frame: i_s_axis_tdata[19:0],
                   count: i_s_axis_tdata[35:20]};
    assign out_free = !r_out_valid || i_m_axis_tready;

    bfa_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_s_axis_tvalid),
        .i_op       (op),
        .o_ready    (seq_ready),
        .i_out_free (out_free),
        .o_done     (seq_done),
        .o_res      (res),
        .o_mem      (mem),
        .i_rdata    (rdata)
    );

    bfa_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_addr  (mem.addr),
        .i_wdata (mem.wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (seq_done) begin
            r_out_data <= {1'b0, res.free_left, res.status, res.alloc_frame};
        end
    end

    assign o_s_axis_tready = seq_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ============================================================================
// Bitmap frame allocator testbench
// Drives operation words into the allocator and checks every result word
// against a bitmap mirror kept in a small scoreboard. A directed opening
// covers the corner cases, then random pool settings follow, each with an
// init and a stream of gets, releases, marks and further inits. Both stream
// sides stall at random outside a steady stretch, and once the result side
// is held off long enough to back up the input.
// ============================================================================
`default_nettype none

module tb_top
    import bfa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    class alloc_scoreboard;
        logic [7:0]  free_map [MAP_BYTES];
        int unsigned init_bytes;
        int unsigned free_total;
        int unsigned pool_base;
        int unsigned pool_size;
        bit          info_in_pool;
        t_result     expected_q[$];
        int unsigned noted;
        int unsigned checked;
        int unsigned errors;
        int unsigned func_seen[4];
        int unsigned status_seen[8];

        function new();
            foreach (free_map[i]) free_map[i] = 8'h00;
            init_bytes   = 0;
            free_total   = 0;
            pool_base    = 0;
            pool_size    = 8;
            info_in_pool = 1'b1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_POOL_BASE:    pool_base = value;
                CFG_POOL_SIZE:    pool_size = value[SIZE_W-1:0];
                CFG_INFO_IN_POOL: info_in_pool = value[0];
                default: ;
            endcase
        endfunction

        function int unsigned work_size();
            int unsigned s;
            s = (pool_size > MAX_FRAMES) ? MAX_FRAMES : pool_size;
            return s - (s % 8);
        endfunction

        function bit in_pool(int unsigned f, output int unsigned off);
            off = 0;
            if (f < pool_base || f - pool_base >= work_size()) return 1'b0;
            off = f - pool_base;
            return 1'b1;
        endfunction

        function bit frame_free(int unsigned off);
            return (free_map[off / 8] & (BYTE_TOP_BIT >> (off % 8))) != 8'h00;
        endfunction

        function int unsigned find_used(int unsigned start);
            int unsigned ws;
            int unsigned off;
            ws = work_size();
            for (int unsigned i = 0; i < ws; i++) begin
                off = (start + i) % ws;
                if (!frame_free(off)) return off;
            end
            return start;
        endfunction

        function bit op_is_safe(t_op op);
            int unsigned off;
            if (op.func == FN_INIT || work_size() / 8 <= init_bytes) return 1'b1;
            if (op.func == FN_GET) return free_total == 0;
            if (op.func == FN_MARK && op.count == 0) return 1'b1;
            return !in_pool(op.frame, off);
        endfunction

        function logic [STAT_W-1:0] take_frame(int unsigned f);
            int unsigned off;
            if (!in_pool(f, off)) return ST_RANGE;
            if (!frame_free(off)) return ST_USED;
            free_map[off / 8] = free_map[off / 8] & ~(BYTE_TOP_BIT >> (off % 8));
            if (free_total > 0) free_total--;
            return ST_OK;
        endfunction

        function void note_op(t_op op);
            t_result     r;
            int unsigned off;
            int unsigned i;
            int unsigned b;
            int unsigned nbytes;
            r = '0;
            r.status = ST_OK;
            case (op.func)
                FN_INIT: begin
                    if (pool_size < 8 || pool_size > MAX_FRAMES || pool_size % 8 != 0) begin
                        r.status = ST_RANGE;
                    end else begin
                        for (i = 0; i < pool_size / 8; i++) free_map[i] = BYTE_ALL_FREE;
                        if (init_bytes < pool_size / 8) init_bytes = pool_size / 8;
                        free_total = pool_size;
                        if (info_in_pool) begin
                            free_map[0] = BYTE_INFO;
                            free_total--;
                        end
                        if (free_total > 16'hFFFF) free_total = 16'hFFFF;
                    end
                end
                FN_GET: begin
                    r.status = ST_NO_FREE;
                    nbytes = work_size() / 8;
                    if (free_total != 0) begin
                        i = 0;
                        while (i < nbytes && free_map[i] == 8'h00) i++;
                        if (i < nbytes) begin
                            b = 0;
                            while ((free_map[i] & (BYTE_TOP_BIT >> b)) == 8'h00) b++;
                            free_map[i] = free_map[i] & ~(BYTE_TOP_BIT >> b);
                            if (free_total > 0) free_total--;
                            r.alloc_frame = FRAME_W'(pool_base + i * 8 + b);
                            r.status = ST_OK;
                        end
                    end
                end
                FN_RELEASE: begin
                    if (!in_pool(op.frame, off)) begin
                        r.status = ST_RANGE;
                    end else if (frame_free(off)) begin
                        r.status = ST_NOT_USED;
                    end else begin
                        free_map[off / 8] = free_map[off / 8] | (BYTE_TOP_BIT >> (off % 8));
                        if (free_total < 16'hFFFF) free_total++;
                    end
                end
                default: begin
                    for (i = 0; i < op.count; i++) begin
                        r.status = take_frame(op.frame + i);
                        if (r.status != ST_OK) break;
                    end
                end
            endcase
            r.free_left = SIZE_W'(free_total);
            expected_q.push_back(r);
            noted++;
            func_seen[op.func]++;
            status_seen[r.status]++;
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [39:0] word);
            t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result word %h with nothing expected", word));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (word[19:0] !== want.alloc_frame)
                report($sformatf("word %0d alloc_frame %h, expected %h",
                                 checked, word[19:0], want.alloc_frame));
            if (word[22:20] !== want.status)
                report($sformatf("word %0d status %0d, expected %0d",
                                 checked, word[22:20], want.status));
            if (word[38:23] !== want.free_left)
                report($sformatf("word %0d free_left %0d, expected %0d",
                                 checked, word[38:23], want.free_left));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [39:0]           s_data = '0;
    logic [1:0]            s_user = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [39:0]           m_data;
    logic                  steady = 1'b0;
    logic                  hold_rx = 1'b0;

    alloc_scoreboard sb = new();
    int unsigned     random_sent;
    int unsigned     settings_run;

    bitmap_frame_allocator DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (m_ready && m_valid) begin
            sb.check_result(m_data);
        end
        m_ready <= !hold_rx && (steady || $urandom_range(99) >= 9);
    end

    initial begin
        do @(posedge clk); while (sb.noted < 500);
        hold_rx <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial begin
        #20ms;
        $display("Timed out with %0d results outstanding.", sb.expected_q.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_op make_op(logic [FUNC_W-1:0] func, int unsigned frame,
                                    int unsigned count);
        t_op op;
        op.func  = func;
        op.frame = FRAME_W'(frame);
        op.count = COUNT_W'(count);
        return op;
    endfunction

    function automatic t_op random_op(bit big);
        int unsigned ws;
        int unsigned span;
        int unsigned pick;
        int unsigned sel;
        int unsigned base;
        ws   = sb.work_size();
        span = (ws == 0) ? 1 : ws;
        base = sb.pool_base;
        pick = $urandom_range(99);
        sel  = $urandom_range(99);
        if (pick < 35) begin
            return make_op(FN_GET, $urandom, $urandom);
        end else if (pick < 60) begin
            if (sel < 70)
                return make_op(FN_RELEASE, base + sb.find_used($urandom_range(span - 1)), 0);
            else if (sel < 85)
                return make_op(FN_RELEASE, base + $urandom_range(span - 1), 0);
            else if (sel < 93)
                return make_op(FN_RELEASE, base + ws + $urandom_range(3), 0);
            else
                return make_op(FN_RELEASE, base - 1 - $urandom_range(3), 0);
        end else if (pick < 88) begin
            if (sel < 5)
                return make_op(FN_MARK, base + $urandom_range(span - 1), 0);
            else if (sel < 80)
                return make_op(FN_MARK, base + $urandom_range(span - 1), $urandom_range(1, 8));
            else if (sel < 90)
                return make_op(FN_MARK, base + $urandom_range(span - 1),
                               big ? $urandom_range(1, 64) : $urandom_range(1, span));
            else
                return make_op(FN_MARK, base + ws - $urandom_range(2), $urandom_range(1, 6));
        end else if (pick < 92) begin
            return make_op(FN_INIT, $urandom, $urandom);
        end
        return make_op(FUNC_W'($urandom_range(3)), $urandom,
                       big ? $urandom_range(64) : $urandom);
    endfunction

    task automatic send_op(t_op op);
        if (!steady && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= op.func;
        s_data  <= {4'b0000, op.count, op.frame};
        do @(posedge clk); while (!s_ready);
        sb.note_op(op);
    endtask

    task automatic wait_idle(int unsigned settle);
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_config(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] size,
                                logic [CFG_DATA_W-1:0] info);
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_POOL_SIZE, size);
        write_reg(CFG_INFO_IN_POOL, info);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_run++;
    endtask

    initial begin
        int unsigned       p;
        int unsigned       n;
        int unsigned       size;
        bit                big;
        logic [FRAME_W-1:0] base;
        t_op               op;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(make_op(FN_GET, 0, 0));
        send_op(make_op(FN_RELEASE, 20'h00100, 0));
        send_op(make_op(FN_MARK, 20'hFFFFF, 1));
        send_op(make_op(FN_INIT, 0, 0));
        send_op(make_op(FN_GET, 0, 0));
        send_op(make_op(FN_RELEASE, 0, 0));
        send_op(make_op(FN_RELEASE, 0, 0));
        send_op(make_op(FN_MARK, 2, 3));
        send_op(make_op(FN_MARK, 1, 2));
        send_op(make_op(FN_MARK, 6, 16'hFFFF));
        send_op(make_op(FN_MARK, 5, 0));
        repeat (3) send_op(make_op(FN_GET, 0, 0));
        send_op(make_op(FN_RELEASE, 8, 0));

        wait_idle(8);
        apply_config(20'hFFFFF, 16, 0);
        send_op(make_op(FN_INIT, 0, 0));
        repeat (2) send_op(make_op(FN_GET, 0, 0));
        send_op(make_op(FN_RELEASE, 20'h00000, 0));
        send_op(make_op(FN_RELEASE, 20'hFFFFF, 0));

        wait_idle(8);
        apply_config(20'hFFFFF, 12, 0);
        send_op(make_op(FN_INIT, 0, 0));
        send_op(make_op(FN_GET, 0, 0));

        wait_idle(8);
        apply_config(0, MAX_FRAMES, 1);
        send_op(make_op(FN_INIT, 0, 0));
        send_op(make_op(FN_MARK, MAX_FRAMES - 8, 9));
        send_op(make_op(FN_GET, 0, 0));

        random_sent = 0;
        while (random_sent < 1900) begin
            wait_idle(8);
            p = $urandom_range(99);
            case ($urandom_range(3))
                0:       base = '0;
                1:       base = FRAME_W'(20'hFFFFF - $urandom_range(300));
                default: base = FRAME_W'($urandom);
            endcase
            if (p < 70) begin
                size = 8 * $urandom_range(1, 32);
            end else if (p < 82) begin
                size = 8 * $urandom_range(33, 512);
            end else if (p < 87) begin
                size = $urandom_range(1) ? MAX_FRAMES : 8 * $urandom_range(3000, 4095);
            end else begin
                case ($urandom_range(2))
                    0:       size = $urandom_range(7);
                    1:       size = 8 * $urandom_range(1, 32) + $urandom_range(1, 7);
                    default: size = $urandom_range(MAX_FRAMES + 1, 65535);
                endcase
            end
            if (p < 95)
                apply_config(base, {4'($urandom), 16'(size)},
                             {19'($urandom), 1'($urandom)});
            big = sb.work_size() > 512;
            send_op(make_op(FN_INIT, $urandom, $urandom));
            random_sent++;
            if (p >= 87 && p < 95)
                n = $urandom_range(4, 12);
            else
                n = big ? $urandom_range(15, 30) : $urandom_range(10, 60);
            repeat (n) begin
                op = random_op(big);
                if (!sb.op_is_safe(op)) op = make_op(FN_INIT, 0, 0);
                steady <= (random_sent >= 900 && random_sent < 1250);
                send_op(op);
                random_sent++;
            end
        end

        wait_idle(32);
        $display("Ran %0d operations (init %0d, get %0d, release %0d, mark %0d)",
                 sb.noted, sb.func_seen[FN_INIT], sb.func_seen[FN_GET],
                 sb.func_seen[FN_RELEASE], sb.func_seen[FN_MARK]);
        $display("over %0d pool settings; statuses: ok %0d, no free %0d, used %0d,",
                 settings_run, sb.status_seen[ST_OK], sb.status_seen[ST_NO_FREE],
                 sb.status_seen[ST_USED]);
        $display("not in use %0d, out of range %0d; %0d mismatches.",
                 sb.status_seen[ST_NOT_USED], sb.status_seen[ST_RANGE], sb.errors);
        if (sb.errors == 0 && sb.checked == sb.noted) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
